// File: rtl/core/srrip_pkg.sv
package srrip_pkg;

    localparam int WAYS       = 4;
    localparam int WAY_IDX_W  = $clog2(WAYS);
    localparam int RRPV_W     = $clog2(WAYS);
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int SHIFT_W    = 5;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 2;
    localparam int OUT_BITS   = 1 + WAY_OUT_W + 1 + TAG_W + 2 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(16);
    localparam logic [RRPV_W-1:0]  RRPV_MAX    = RRPV_W'(WAYS - 1);
    localparam logic [RRPV_W-1:0]  RRPV_INS    = (WAYS <= 2) ? '0 : RRPV_W'(2);

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// File: rtl/core/srrip_ctrl.sv
module srrip_ctrl
    import srrip_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/srrip_dp.sv
module srrip_dp
    import srrip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [SHIFT_W-1:0]    i_cfg_wdata,
    input  logic [ADDR_W-1:0]     i_addr,
    output logic [OUT_DATA_W-1:0] o_result
);

    logic [SHIFT_W-1:0]   r_shift;
    logic [TAG_W-1:0]     r_tag;
    logic [WAYS-1:0]      r_valid;
    logic [TAG_W-1:0]     r_way_tag [WAYS];
    logic [RRPV_W-1:0]    r_rrpv [WAYS];
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_miss_cnt;
    logic [OUT_DATA_W-1:0] r_result;

    logic [WAYS-1:0]      hit_vec;
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_idx;
    logic [WAYS-1:0]      present;
    logic [RRPV_W-1:0]    top;
    logic [RRPV_W-1:0]    diff;
    logic [WAY_IDX_W-1:0] vic_idx;
    logic [WAY_IDX_W-1:0] way_idx;
    logic [WAY_IDX_W+1:0] way_ext;
    logic                 ev_valid;
    logic [TAG_W-1:0]     ev_tag;
    logic [CNT_W-1:0]     n_hit_cnt;
    logic [CNT_W-1:0]     n_miss_cnt;

    always_comb begin
        hit_idx = '0;
        vic_idx = '0;
        top     = '0;
        present = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = r_valid[w] && (r_way_tag[w] == r_tag);
        end
        hit = |hit_vec;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_IDX_W'(w);
            end
        end
        for (int v = 0; v < WAYS; v++) begin
            for (int w = 0; w < WAYS; w++) begin
                if (r_rrpv[w] == RRPV_W'(v)) begin
                    present[v] = 1'b1;
                end
            end
        end
        for (int v = 0; v < WAYS; v++) begin
            if (present[v]) begin
                top = RRPV_W'(v);
            end
        end
        diff = RRPV_MAX - top;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rrpv[w] == top) begin
                vic_idx = WAY_IDX_W'(w);
            end
        end
        way_idx    = hit ? hit_idx : vic_idx;
        way_ext    = {2'b00, way_idx};
        ev_valid   = !hit && r_valid[vic_idx];
        ev_tag     = ev_valid ? r_way_tag[vic_idx] : '0;
        n_hit_cnt  = r_hit_cnt + CNT_W'(hit);
        n_miss_cnt = r_miss_cnt + CNT_W'(!hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= SHIFT_RESET;
            r_valid    <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            for (int w = 0; w < WAYS; w++) begin
                r_rrpv[w] <= RRPV_MAX;
            end
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
                if (hit) begin
                    r_rrpv[hit_idx] <= '0;
                end else begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (vic_idx == WAY_IDX_W'(w)) begin
                            r_rrpv[w] <= RRPV_INS;
                        end else begin
                            r_rrpv[w] <= r_rrpv[w] + diff;
                        end
                    end
                    r_valid[vic_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= i_addr >> r_shift;
        end
        if (i_cmd.exec) begin
            if (!hit) begin
                r_way_tag[vic_idx] <= r_tag;
            end
            r_result <= OUT_DATA_W'({n_miss_cnt, n_hit_cnt, ev_tag, ev_valid,
                                     way_ext[WAY_OUT_W-1:0], hit});
        end
    end

    assign o_result = r_result;

endmodule

// File: rtl/core/srrip_set_replacement.sv
// Channel   Direction  tdata fields, lowest bit first
// s_axis    in         access_address[31:0]
// m_axis    out        was_hit[0], way_used[2:1], evicted_valid[3], evicted_tag[35:4],
//                      hit_total[67:36], miss_total[99:68], zero fill[103:100]
// cfg       in         tag_shift[4:0], written whenever i_cfg_we is high
//
// The tag is first formed through the shifter and registered, then all ways are
// compared, the victim picked and the set updated. The next item is taken while a
// result waits in the output register; a stalled output holds the next item's lookup.
// Reset is synchronous and clears all ways, both counts, and sets tag_shift to 16.
module srrip_set_replacement
    import srrip_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SHIFT_W-1:0]    i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ADDR_W-1:0]     s_axis_tdata,   // access_address
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // was_hit, way_used, evicted_valid,
                                                  // evicted_tag, hit_total, miss_total
);

    t_cmd cmd;

    srrip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    srrip_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_addr      (s_axis_tdata),
        .o_result    (m_axis_tdata)
    );

endmodule

// File: rtl/core/srrip_checker.sv
module srrip_checker
    import srrip_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output item changed or dropped.");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken while a lookup is pending.");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[3] && m_axis_tdata[35:4] == '0)
        else $error("Hit item reports an eviction.");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0])
        else $error("Eviction reported on a hit.");

endmodule

bind srrip_set_replacement srrip_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
